// ===== design/lpm_pkg.sv =====
// ----------------------------------------------------------------------------
// lpm_pkg
// Shared types and constants for the longest prefix match routing table.
// ----------------------------------------------------------------------------
package lpm_pkg;

  localparam int unsigned DefTableDepth = 16;
  localparam int unsigned IndexW        = 4;
  localparam int unsigned AddrW         = 32;
  // A write can only reach slots an entry_index can name.
  localparam int unsigned MaxSlots      = 2 ** IndexW;

  localparam logic OpWrite  = 1'b0;
  localparam logic OpLookup = 1'b1;

  typedef struct packed {
    logic             en;
    logic [IndexW-1:0] idx;
    logic [AddrW-1:0] prefix;
    logic [AddrW-1:0] mask;
    logic             valid;
  } mem_wr_t;

  typedef struct packed {
    logic             valid;
    logic [AddrW-1:0] prefix;
    logic [AddrW-1:0] mask;
  } route_entry_t;

  typedef enum logic [3:0] {
    StIdle  = 4'b0001,
    StScan  = 4'b0010,
    StDrain = 4'b0100,
    StHold  = 4'b1000
  } state_e;

endpackage

// ===== design/lpm_route_mem.sv =====
// ----------------------------------------------------------------------------
// lpm_route_mem
// Route storage: prefix/mask memory with registered read, valid bits in flops.
// ----------------------------------------------------------------------------
module lpm_route_mem #(
  parameter int unsigned ScanDepth = 16,
  parameter int unsigned IdxW      = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  lpm_pkg::mem_wr_t      wr_i,
  input  logic [IdxW-1:0]       rd_idx_i,
  output lpm_pkg::route_entry_t rd_entry_o
);
  import lpm_pkg::*;

  logic [2*AddrW-1:0] mem_q [ScanDepth];
  logic [ScanDepth-1:0] valid_q;
  logic [2*AddrW-1:0] rd_data_q;
  logic rd_valid_q;
  logic [IdxW-1:0] wr_idx;

  assign wr_idx = wr_i.idx[IdxW-1:0];

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_idx] <= {wr_i.prefix, wr_i.mask};
    end
    rd_data_q <= mem_q[rd_idx_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_i.en) begin
        valid_q[wr_idx] <= wr_i.valid;
      end
      rd_valid_q <= valid_q[rd_idx_i];
    end
  end

  assign rd_entry_o.valid  = rd_valid_q;
  assign rd_entry_o.prefix = rd_data_q[2*AddrW-1:AddrW];
  assign rd_entry_o.mask   = rd_data_q[AddrW-1:0];

endmodule

// ===== design/lpm_search.sv =====
// ----------------------------------------------------------------------------
// lpm_search
// Item control: decodes writes, walks the table on lookups, keeps the best
// match and holds the result in an output register.
// ----------------------------------------------------------------------------
module lpm_search #(
  parameter int unsigned TableDepth = 16,
  parameter int unsigned ScanDepth  = 16,
  parameter int unsigned IdxW       = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          op_i,
  input  logic [lpm_pkg::IndexW-1:0]    entry_index_i,
  input  logic [lpm_pkg::AddrW-1:0]     address_i,
  input  logic [lpm_pkg::AddrW-1:0]     prefix_mask_i,
  input  logic                          entry_valid_i,
  output lpm_pkg::mem_wr_t              wr_o,
  output logic [IdxW-1:0]               rd_idx_o,
  input  lpm_pkg::route_entry_t         rd_entry_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          hit_o,
  output logic [lpm_pkg::IndexW-1:0]    match_index_o,
  output logic [lpm_pkg::AddrW-1:0]     match_mask_o
);
  import lpm_pkg::*;

  localparam logic [IdxW-1:0] ScanLast = IdxW'(ScanDepth - 1);

  state_e state_q, state_d;
  logic [IdxW-1:0]  scan_q;
  logic [IdxW-1:0]  cmp_idx_q;
  logic             cmp_vld_q;
  logic [AddrW-1:0] dest_q;
  logic             found_q, found_d;
  logic [IdxW-1:0]  best_idx_q, best_idx_d;
  logic [AddrW-1:0] best_mask_q, best_mask_d;
  logic             out_valid_q;
  logic             hit_q;
  logic [IndexW-1:0] match_index_q;
  logic [AddrW-1:0] match_mask_q;
  logic in_fire, lookup_fire, out_free, load_out, take;

  assign in_ready_o  = (state_q == StIdle);
  assign in_fire     = in_valid_i && in_ready_o;
  assign lookup_fire = in_fire && (op_i == OpLookup);
  assign out_free    = !out_valid_q || out_ready_i;

  // Writes beyond the table are dropped.
  always_comb begin
    wr_o.en     = in_fire && (op_i == OpWrite) &&
                  (32'(entry_index_i) < 32'(TableDepth));
    wr_o.idx    = entry_index_i;
    wr_o.prefix = address_i;
    wr_o.mask   = prefix_mask_i;
    wr_o.valid  = entry_valid_i;
  end

  assign rd_idx_o = scan_q;

  // Compare stage on the registered read data.
  always_comb begin
    take = cmp_vld_q && rd_entry_i.valid &&
           ((dest_q & rd_entry_i.mask) == (rd_entry_i.prefix & rd_entry_i.mask)) &&
           (!found_q || (rd_entry_i.mask > best_mask_q));
    found_d     = found_q;
    best_idx_d  = best_idx_q;
    best_mask_d = best_mask_q;
    if (take) begin
      found_d     = 1'b1;
      best_idx_d  = cmp_idx_q;
      best_mask_d = rd_entry_i.mask;
    end
  end

  always_comb begin
    state_d  = state_q;
    load_out = 1'b0;
    unique case (state_q)
      StIdle:  if (lookup_fire) state_d = StScan;
      StScan:  if (scan_q == ScanLast) state_d = StDrain;
      StDrain: begin
        if (out_free) begin
          load_out = 1'b1;
          state_d  = StIdle;
        end else begin
          state_d = StHold;
        end
      end
      StHold: begin
        if (out_free) begin
          load_out = 1'b1;
          state_d  = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      scan_q      <= '0;
      cmp_vld_q   <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cmp_vld_q <= (state_q == StScan);
      if (lookup_fire) begin
        scan_q  <= '0;
        found_q <= 1'b0;
      end else begin
        found_q <= found_d;
        if (state_q == StScan && scan_q != ScanLast) begin
          scan_q <= scan_q + 1'b1;
        end
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q   <= scan_q;
    best_idx_q  <= best_idx_d;
    best_mask_q <= best_mask_d;
    if (lookup_fire) begin
      dest_q <= address_i;
    end
    // In drain the last entry is still in the compare stage, so use _d.
    if (load_out) begin
      hit_q         <= found_d;
      match_index_q <= found_d ? IndexW'(best_idx_d) : '0;
      match_mask_q  <= found_d ? best_mask_d : '0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign hit_o         = hit_q;
  assign match_index_o = match_index_q;
  assign match_mask_o  = match_mask_q;

endmodule

// ===== design/longest_prefix_match_table.sv =====
// ----------------------------------------------------------------------------
// longest_prefix_match_table
// IPv4 routing table with longest prefix match lookup, one entry per cycle.
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid_i/in_ready_o | op, entry_index, address,
//           |           |                      | prefix_mask, entry_valid
//   out     | output    | out_valid_o/out_ready_i | hit, match_index, match_mask
//
// A write item is done when it is taken and leaves the block idle. A lookup walks
// min(TABLE_DEPTH,16) entries through the single read port of the route memory,
// one per cycle, then passes the drain state, where the result loads into the
// output register; the next item is taken once the block is back in idle.
// Reset clears the valid bits at once; no clearing pass is needed.
// A stalled result waits in the output register; a finished lookup holds its
// best match until that register frees.
// ----------------------------------------------------------------------------
module longest_prefix_match_table #(
  parameter int unsigned TABLE_DEPTH = lpm_pkg::DefTableDepth
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       op_i,
  input  logic [lpm_pkg::IndexW-1:0] entry_index_i,
  input  logic [lpm_pkg::AddrW-1:0]  address_i,
  input  logic [lpm_pkg::AddrW-1:0]  prefix_mask_i,
  input  logic                       entry_valid_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       hit_o,
  output logic [lpm_pkg::IndexW-1:0] match_index_o,
  output logic [lpm_pkg::AddrW-1:0]  match_mask_o
);
  import lpm_pkg::*;

  // Slots at or above MaxSlots can never be written, so they never match.
  localparam int unsigned ScanDepth = (TABLE_DEPTH < MaxSlots) ? TABLE_DEPTH : MaxSlots;
  localparam int unsigned IdxW      = (ScanDepth > 1) ? $clog2(ScanDepth) : 1;

  mem_wr_t         mem_wr;
  route_entry_t    rd_entry;
  logic [IdxW-1:0] rd_idx;

  lpm_route_mem #(
    .ScanDepth(ScanDepth),
    .IdxW     (IdxW)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (mem_wr),
    .rd_idx_i  (rd_idx),
    .rd_entry_o(rd_entry)
  );

  lpm_search #(
    .TableDepth(TABLE_DEPTH),
    .ScanDepth (ScanDepth),
    .IdxW      (IdxW)
  ) u_search (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .op_i         (op_i),
    .entry_index_i(entry_index_i),
    .address_i    (address_i),
    .prefix_mask_i(prefix_mask_i),
    .entry_valid_i(entry_valid_i),
    .wr_o         (mem_wr),
    .rd_idx_o     (rd_idx),
    .rd_entry_i   (rd_entry),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .hit_o        (hit_o),
    .match_index_o(match_index_o),
    .match_mask_o (match_mask_o)
  );

endmodule

// ===== tb/tb_longest_prefix_match_table.sv =====
// ----------------------------------------------------------------------------
// tb_longest_prefix_match_table
// Self-checking bench for the routing table. It loads entries, runs lookups and
// checks every lookup result against a scoreboard of predicted best matches.
// Both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module tb_longest_prefix_match_table;

  import lpm_pkg::*;

  localparam int unsigned Depth = DefTableDepth;

  typedef struct {
    logic              op;
    logic [IndexW-1:0] slot;
    logic [AddrW-1:0]  addr;
    logic [AddrW-1:0]  mask;
    logic              ent_valid;
  } route_cmd_t;

  typedef struct {
    logic              hit;
    logic [IndexW-1:0] idx;
    logic [AddrW-1:0]  mask;
  } route_match_t;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              in_valid_i    = 1'b0;
  logic              in_ready_o;
  logic              op_i          = OpWrite;
  logic [IndexW-1:0] entry_index_i = '0;
  logic [AddrW-1:0]  address_i     = '0;
  logic [AddrW-1:0]  prefix_mask_i = '0;
  logic              entry_valid_i = 1'b0;
  logic              out_valid_o;
  logic              out_ready_i   = 1'b0;
  logic              hit_o;
  logic [IndexW-1:0] match_index_o;
  logic [AddrW-1:0]  match_mask_o;

  route_cmd_t   pending_cmds[$];
  route_match_t expected_matches[$];

  // predictor copy of the table
  logic [AddrW-1:0] tbl_prefix[Depth];
  logic [AddrW-1:0] tbl_mask[Depth];
  logic             tbl_valid[Depth];

  // stimulus-side mirror, used only to aim lookups at live entries
  logic [AddrW-1:0] gen_prefix[Depth];
  logic [AddrW-1:0] gen_mask[Depth];
  logic             gen_valid[Depth];

  int n_total    = 0;
  int n_accepted = 0;
  int err_cnt    = 0;

  route_cmd_t cur_cmd;
  logic       holding   = 1'b0;
  int         send_gap  = 0;
  int         send_calm = 0;
  int         recv_stall = 0;
  int         recv_calm  = 0;

  always #2 clk_i = ~clk_i;

  longest_prefix_match_table u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .op_i          (op_i),
    .entry_index_i (entry_index_i),
    .address_i     (address_i),
    .prefix_mask_i (prefix_mask_i),
    .entry_valid_i (entry_valid_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .hit_o         (hit_o),
    .match_index_o (match_index_o),
    .match_mask_o  (match_mask_o)
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 20);
    return $urandom_range(21, 80);
  endfunction

  function automatic logic [AddrW-1:0] mask_of_len(int len);
    if (len == 0) return '0;
    return 32'hFFFF_FFFF << (32 - len);
  endfunction

  // largest mask wins; only a strictly larger mask displaces, so ties keep
  // the lowest slot
  function automatic route_match_t predict_match(logic [AddrW-1:0] dest);
    route_match_t best;
    best = '{hit: 1'b0, idx: '0, mask: '0};
    for (int s = 0; s < Depth; s++) begin
      if (tbl_valid[s] && ((dest & tbl_mask[s]) == (tbl_prefix[s] & tbl_mask[s]))) begin
        if (!best.hit || tbl_mask[s] > best.mask) begin
          best.hit  = 1'b1;
          best.idx  = IndexW'(s);
          best.mask = tbl_mask[s];
        end
      end
    end
    return best;
  endfunction

  task automatic add_write(int slot, logic [AddrW-1:0] prefix, logic [AddrW-1:0] mask,
                           logic ent_valid);
    pending_cmds.push_back('{op: OpWrite, slot: IndexW'(slot), addr: prefix, mask: mask,
                             ent_valid: ent_valid});
    gen_prefix[slot] = prefix;
    gen_mask[slot]   = mask;
    gen_valid[slot]  = ent_valid;
  endtask

  // entry_index, mask and valid are don't-care on a lookup: fill with noise
  task automatic add_lookup(logic [AddrW-1:0] dest);
    pending_cmds.push_back('{op: OpLookup, slot: IndexW'($urandom), addr: dest,
                             mask: $urandom, ent_valid: 1'($urandom)});
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      holding    = 1'b0;
      for (int s = 0; s < Depth; s++) tbl_valid[s] = 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        n_accepted++;
        holding = 1'b0;
        if (cur_cmd.op == OpWrite) begin
          if (cur_cmd.slot < Depth) begin
            tbl_prefix[cur_cmd.slot] = cur_cmd.addr;
            tbl_mask[cur_cmd.slot]   = cur_cmd.mask;
            tbl_valid[cur_cmd.slot]  = cur_cmd.ent_valid;
          end
        end else begin
          expected_matches.push_back(predict_match(cur_cmd.addr));
        end
      end
      if (!holding) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          cur_cmd = pending_cmds.pop_front();
          op_i          <= cur_cmd.op;
          entry_index_i <= cur_cmd.slot;
          address_i     <= cur_cmd.addr;
          prefix_mask_i <= cur_cmd.mask;
          entry_valid_i <= cur_cmd.ent_valid;
          in_valid_i    <= 1'b1;
          holding = 1'b1;
          if (send_calm > 0) begin
            send_calm--;
            send_gap = 0;
          end else if ($urandom_range(0, 29) == 0) begin
            send_calm = $urandom_range(20, 60);
            send_gap  = 0;
          end else begin
            send_gap = pick_gap();
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor and scoreboard
  always @(posedge clk_i or negedge rst_ni) begin
    route_match_t exp_m;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_matches.size() == 0) begin
          $display("%0t: unexpected result hit=%0b index=%0d mask=%h",
                   $time, hit_o, match_index_o, match_mask_o);
          err_cnt++;
        end else begin
          exp_m = expected_matches.pop_front();
          if (hit_o !== exp_m.hit) begin
            $display("%0t: hit mismatch, expected %0b actual %0b", $time, exp_m.hit, hit_o);
            err_cnt++;
          end
          if (match_index_o !== exp_m.idx) begin
            $display("%0t: match_index mismatch, expected %0d actual %0d",
                     $time, exp_m.idx, match_index_o);
            err_cnt++;
          end
          if (match_mask_o !== exp_m.mask) begin
            $display("%0t: match_mask mismatch, expected %h actual %h",
                     $time, exp_m.mask, match_mask_o);
            err_cnt++;
          end
        end
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if (recv_calm > 0) begin
          recv_calm--;
        end else if ($urandom_range(0, 199) == 0) begin
          recv_calm = $urandom_range(40, 200);
        end else if ($urandom_range(0, 5) == 0) begin
          recv_stall = pick_gap();
        end
      end
    end
  end

  // stimulus
  initial begin
    int r;
    int slot;
    int nvalid;
    int cand[Depth];
    logic [AddrW-1:0] a;
    logic [AddrW-1:0] m;

    for (int s = 0; s < Depth; s++) begin
      gen_prefix[s] = '0;
      gen_mask[s]   = '0;
      gen_valid[s]  = 1'b0;
    end

    add_lookup(32'h0A00_0001);                          // empty table: miss
    add_write(0, 32'hDEAD_BEEF, 32'h0, 1'b1);           // default route
    add_lookup(32'hFFFF_FFFF);
    add_write(15, 32'hC0A8_01FF, 32'hFFFF_FF00, 1'b1);  // prefix bits outside mask
    add_lookup(32'hC0A8_01FF);
    add_write(7, 32'hC0A8_0100, 32'hFFFF_FF00, 1'b1);   // same mask as slot 15
    add_lookup(32'hC0A8_0142);                          // tie -> lower slot
    add_write(3, 32'hC0A8_0142, 32'hFFFF_FFFF, 1'b1);   // host route
    add_lookup(32'hC0A8_0142);
    add_write(3, 32'h0000_0000, 32'h0000_0000, 1'b0);   // remove it
    add_lookup(32'hC0A8_0142);
    add_write(9, 32'hAAAA_AAAA, 32'hF0F0_F0F0, 1'b1);   // non-contiguous mask
    add_lookup(32'hAFAF_AFA5);
    add_write(0, 32'h0000_0000, 32'h0000_0000, 1'b0);   // drop default
    add_lookup(32'h0102_0304);                          // miss
    add_write(15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    add_lookup(32'hFFFF_FFFF);
    add_lookup(32'h0000_0000);
    add_write(1, 32'h0000_0000, 32'h8000_0000, 1'b1);   // 0.0.0.0/1
    add_lookup(32'h7FFF_FFFF);

    for (int k = 0; k < 880; k++) begin
      r = $urandom_range(0, 99);
      if (r < 35) begin
        slot = $urandom_range(0, Depth - 1);
        r = $urandom_range(0, 99);
        if (r < 70) m = mask_of_len($urandom_range(0, 32));
        else if (r < 85) m = $urandom;
        else m = gen_mask[$urandom_range(0, Depth - 1)];  // provoke equal masks
        add_write(slot, $urandom, m, $urandom_range(0, 99) < 85);
      end else begin
        nvalid = 0;
        for (int s = 0; s < Depth; s++) begin
          if (gen_valid[s]) begin
            cand[nvalid] = s;
            nvalid++;
          end
        end
        if (nvalid > 0 && $urandom_range(0, 99) < 75) begin
          slot = cand[$urandom_range(0, nvalid - 1)];
          a = (gen_prefix[slot] & gen_mask[slot]) | ($urandom & ~gen_mask[slot]);
          if ($urandom_range(0, 4) == 0) a = a ^ (32'h1 << $urandom_range(0, 31));
        end else begin
          a = $urandom;
        end
        add_lookup(a);
      end
    end
    n_total = pending_cmds.size();

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (n_accepted < n_total || expected_matches.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/lpm_pkg.sv
design/lpm_route_mem.sv
design/lpm_search.sv
design/longest_prefix_match_table.sv
tb/tb_longest_prefix_match_table.sv
